>>> src/eight_channel_dma_engine_core_assert.svh
// Assertion macros for the DMA engine core.
// ECDMA_ASSERT checks a property on every clock while reset is released.
// ECDMA_ASSERT_NEXT checks that a condition holds in the clock after a trigger.
`ifndef EIGHT_CHANNEL_DMA_ENGINE_CORE_ASSERT_SVH
`define EIGHT_CHANNEL_DMA_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define ECDMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`define ECDMA_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`else

`define ECDMA_ASSERT(lbl, prop, msg)

`define ECDMA_ASSERT_NEXT(lbl, trig, cons, msg)

`endif

`endif

>>> src/ecdma_pkg.sv
`default_nettype none

package ecdma_pkg;

    // Default number of implemented channels.
    localparam int ECDMA_CHANNELS = 8;

    // Commands carried by an input item.
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_START = 2'd2,
        CMD_STEP  = 2'd3
    } t_cmd;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Register byte offsets within a channel.
    localparam logic [3:0] OFF_PARAM      = 4'd0;
    localparam logic [3:0] OFF_B_ADDR     = 4'd1;
    localparam logic [3:0] OFF_A_ADDR_LO  = 4'd2;
    localparam logic [3:0] OFF_A_ADDR_HI  = 4'd3;
    localparam logic [3:0] OFF_BANK       = 4'd4;
    localparam logic [3:0] OFF_COUNT_LO   = 4'd5;
    localparam logic [3:0] OFF_COUNT_HI   = 4'd6;
    localparam logic [3:0] OFF_IND_BANK   = 4'd7;
    localparam logic [3:0] OFF_TABLE_LO   = 4'd8;
    localparam logic [3:0] OFF_TABLE_HI   = 4'd9;
    localparam logic [3:0] OFF_LINE_CNT   = 4'd10;
    localparam logic [3:0] OFF_SPARE      = 4'd11;

    // Transfer modes (param bits 2:0).
    localparam logic [2:0] MODE_SINGLE     = 3'd0;
    localparam logic [2:0] MODE_PAIR       = 3'd1;
    localparam logic [2:0] MODE_TWICE      = 3'd2;
    localparam logic [2:0] MODE_PAIR_TWICE = 3'd3;
    localparam logic [2:0] MODE_QUAD       = 3'd4;

    // A address step selections (param bits 4:3).
    localparam logic [1:0] STEP_INC = 2'd0;
    localparam logic [1:0] STEP_DEC = 2'd2;

    // A write of the B address byte forces this high part.
    localparam logic [15:0] B_ADDR_BASE = 16'h2100;

    // A zero byte count stands for a full 64K transfer.
    localparam logic [16:0] FULL_COUNT = 17'h10000;

    // One channel's register file, stored as one memory row.
    typedef struct packed {
        logic [7:0]  spare;
        logic [7:0]  line_counter;
        logic [15:0] table_address;
        logic [7:0]  indirect_bank;
        logic [15:0] byte_count;
        logic [7:0]  bank;
        logic [15:0] a_address;
        logic [15:0] b_address;
        logic [7:0]  param;
    } t_chan_row;

endpackage

`default_nettype wire

>>> src/ecdma_ram.sv
`default_nettype none

module ecdma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                        i_wr_data,
    input  wire logic                                    i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/eight_channel_dma_engine_core.sv
// Eight-channel DMA engine core.
// Input channel (i_in_valid / o_in_stall) carries one command item: a register
// write, a register read, a channel start or a step that yields one byte move.
// Output channel (o_out_valid / i_out_stall) returns exactly one result item
// per command: the read byte, or the A/B bus addresses, direction and last flag
// of a byte move. Fields that a command does not produce are zero.
// The channel row of a command is read from the register memory at the edge
// that accepts it, and the result is registered once the output register is
// free. No new item is taken until the current one has executed; the
// read-modify-write of the channel memory row sets that.
// While the receiver stalls, the finished result holds on the output and one
// more command may be accepted; its write-back and result wait until the output
// register frees up, and the input stalls meanwhile.
// Reset clears the engine state and marks every channel row as unwritten, so
// all register bytes read as all ones until written. No clearing pass is run:
// the block accepts items as soon as reset is released.
`default_nettype none

`include "eight_channel_dma_engine_core_assert.svh"

module eight_channel_dma_engine_core #(
    parameter int CHANNELS = ecdma_pkg::ECDMA_CHANNELS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [6:0]  i_reg_address,
    input  wire logic [7:0]  i_write_data,
    input  wire logic [2:0]  i_channel,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [7:0]  o_read_data,
    output logic             o_move_valid,
    output logic      [23:0] o_a_bus_address,
    output logic      [15:0] o_b_bus_address,
    output logic             o_b_to_a,
    output logic             o_last_move
);

    import ecdma_pkg::*;

    localparam int         CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int         ROW_W    = $bits(t_chan_row);
    localparam logic [3:0] CH_LIMIT = 4'(CHANNELS);

    // Sequencer and handshake.
    t_state r_state, n_state;
    logic   w_in_accept;
    logic   w_out_free;
    logic   w_exec_fire;
    logic   w_rd_en;
    logic   w_ram_wr_en;

    // Latched command item.
    t_cmd       r_cmd;
    logic [6:0] r_reg_address;
    logic [7:0] r_write_data;
    logic [2:0] r_channel;
    logic [CH_W-1:0] r_row_addr;

    // Engine state kept in flip-flops.
    logic        r_engine_active, n_engine_active;
    logic [2:0]  r_active_channel, n_active_channel;
    logic [16:0] r_remaining, n_remaining;
    logic [1:0]  r_unit_position, n_unit_position;

    // Rows that have been written since reset; others read as all ones.
    logic [CHANNELS-1:0] r_row_valid;

    // Memory row path.
    logic [ROW_W-1:0] w_rd_data;
    t_chan_row        w_row;
    t_chan_row        n_row;
    logic             w_wr_req;
    logic [CH_W-1:0]  w_rd_addr;

    // Result being built and the output register.
    logic        r_out_valid;
    logic [7:0]  r_read_data,  n_read_data;
    logic        r_move_valid, n_move_valid;
    logic [23:0] r_a_bus,      n_a_bus;
    logic [15:0] r_b_bus,      n_b_bus;
    logic        r_b_to_a,     n_b_to_a;
    logic        r_last_move,  n_last_move;

    // Decode helpers.
    logic [2:0] w_reg_ch;
    logic [3:0] w_reg_off;
    logic       w_reg_ch_ok;
    logic       w_start_ch_ok;
    logic       w_active_ch_ok;
    logic [2:0] w_mode;
    logic [1:0] w_b_offset;
    logic [1:0] w_step_sel;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Row address of the command: register channel, start channel or the
    // channel the engine is working on.
    always_comb begin
        unique case (t_cmd'(i_command))
            CMD_WRITE, CMD_READ: w_rd_addr = i_reg_address[4 +: CH_W];
            CMD_START:           w_rd_addr = i_channel[CH_W-1:0];
            CMD_STEP:            w_rd_addr = r_active_channel[CH_W-1:0];
            default:             w_rd_addr = i_channel[CH_W-1:0];
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall  = 1'b1;
        w_rd_en     = 1'b0;
        w_exec_fire = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                w_rd_en    = w_in_accept;
            end
            ST_EXEC: begin
                w_exec_fire = w_out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    ecdma_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CHANNELS)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr_en),
        .i_wr_addr (r_row_addr),
        .i_wr_data (n_row),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_ram_wr_en = w_exec_fire && w_wr_req;

    // A row never written since reset holds the reset value of all ones.
    assign w_row = r_row_valid[r_row_addr] ? t_chan_row'(w_rd_data) : t_chan_row'('1);

    assign w_reg_ch       = r_reg_address[6:4];
    assign w_reg_off      = r_reg_address[3:0];
    assign w_reg_ch_ok    = {1'b0, w_reg_ch} < CH_LIMIT;
    assign w_start_ch_ok  = {1'b0, r_channel} < CH_LIMIT;
    assign w_active_ch_ok = {1'b0, r_active_channel} < CH_LIMIT;
    assign w_mode         = w_row.param[2:0];
    assign w_step_sel     = w_row.param[4:3];

    // B offset pattern of the transfer mode.
    always_comb begin
        case (w_mode)
            MODE_PAIR:       w_b_offset = {1'b0, r_unit_position[0]};
            MODE_PAIR_TWICE: w_b_offset = {1'b0, r_unit_position[1]};
            MODE_QUAD:       w_b_offset = r_unit_position;
            default:         w_b_offset = 2'd0;
        endcase
    end

    // Command execution on the row read when the command was accepted.
    always_comb begin
        n_row            = w_row;
        w_wr_req         = 1'b0;
        n_engine_active  = r_engine_active;
        n_active_channel = r_active_channel;
        n_remaining      = r_remaining;
        n_unit_position  = r_unit_position;
        n_read_data      = 8'd0;
        n_move_valid     = 1'b0;
        n_a_bus          = 24'd0;
        n_b_bus          = 16'd0;
        n_b_to_a         = 1'b0;
        n_last_move      = 1'b0;

        case (r_cmd)
            CMD_WRITE: begin
                if (w_reg_ch_ok) begin
                    w_wr_req = 1'b1;
                    unique case (w_reg_off)
                        OFF_PARAM:     n_row.param               = r_write_data;
                        OFF_B_ADDR:    n_row.b_address           = B_ADDR_BASE
                                                                 | {8'd0, r_write_data};
                        OFF_A_ADDR_LO: n_row.a_address[7:0]      = r_write_data;
                        OFF_A_ADDR_HI: n_row.a_address[15:8]     = r_write_data;
                        OFF_BANK:      n_row.bank                = r_write_data;
                        OFF_COUNT_LO:  n_row.byte_count[7:0]     = r_write_data;
                        OFF_COUNT_HI:  n_row.byte_count[15:8]    = r_write_data;
                        OFF_IND_BANK:  n_row.indirect_bank       = r_write_data;
                        OFF_TABLE_LO:  n_row.table_address[7:0]  = r_write_data;
                        OFF_TABLE_HI:  n_row.table_address[15:8] = r_write_data;
                        OFF_LINE_CNT:  n_row.line_counter        = r_write_data;
                        OFF_SPARE:     n_row.spare               = r_write_data;
                        default:       w_wr_req                  = 1'b0;
                    endcase
                end
            end
            CMD_READ: begin
                if (w_reg_ch_ok) begin
                    unique case (w_reg_off)
                        OFF_PARAM:     n_read_data = w_row.param;
                        OFF_B_ADDR:    n_read_data = w_row.b_address[7:0];
                        OFF_A_ADDR_LO: n_read_data = w_row.a_address[7:0];
                        OFF_A_ADDR_HI: n_read_data = w_row.a_address[15:8];
                        OFF_BANK:      n_read_data = w_row.bank;
                        OFF_COUNT_LO:  n_read_data = w_row.byte_count[7:0];
                        OFF_COUNT_HI:  n_read_data = w_row.byte_count[15:8];
                        OFF_IND_BANK:  n_read_data = w_row.indirect_bank;
                        OFF_TABLE_LO:  n_read_data = w_row.table_address[7:0];
                        OFF_TABLE_HI:  n_read_data = w_row.table_address[15:8];
                        OFF_LINE_CNT:  n_read_data = w_row.line_counter;
                        OFF_SPARE:     n_read_data = w_row.spare;
                        default:       n_read_data = 8'd0;
                    endcase
                end
            end
            CMD_START: begin
                if (w_start_ch_ok && (w_mode <= MODE_QUAD)) begin
                    n_engine_active  = 1'b1;
                    n_active_channel = r_channel;
                    n_remaining      = (w_row.byte_count == 16'd0)
                                     ? FULL_COUNT : {1'b0, w_row.byte_count};
                    n_unit_position  = 2'd0;
                end
            end
            CMD_STEP: begin
                if (r_engine_active) begin
                    if (!w_active_ch_ok || (w_mode > MODE_QUAD)) begin
                        n_engine_active = 1'b0;
                    end else begin
                        w_wr_req     = 1'b1;
                        n_move_valid = 1'b1;
                        n_a_bus      = {w_row.bank, w_row.a_address};
                        n_b_bus      = w_row.b_address + {14'd0, w_b_offset};
                        n_b_to_a     = w_row.param[7];
                        if (w_step_sel == STEP_INC) begin
                            n_row.a_address = w_row.a_address + 16'd1;
                        end else if (w_step_sel == STEP_DEC) begin
                            n_row.a_address = w_row.a_address - 16'd1;
                        end
                        n_unit_position  = r_unit_position + 2'd1;
                        n_remaining      = r_remaining - 17'd1;
                        n_row.byte_count = n_remaining[15:0];
                        if (n_remaining == 17'd0) begin
                            n_last_move     = 1'b1;
                            n_engine_active = 1'b0;
                        end
                    end
                end
            end
            default: n_read_data = 8'd0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_engine_active  <= 1'b0;
            r_active_channel <= 3'd0;
            r_remaining      <= 17'd0;
            r_unit_position  <= 2'd0;
            r_row_valid      <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_exec_fire) begin
                r_engine_active  <= n_engine_active;
                r_active_channel <= n_active_channel;
                r_remaining      <= n_remaining;
                r_unit_position  <= n_unit_position;
            end
            if (w_ram_wr_en) begin
                r_row_valid[r_row_addr] <= 1'b1;
            end
            if (w_exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_cmd         <= t_cmd'(i_command);
            r_reg_address <= i_reg_address;
            r_write_data  <= i_write_data;
            r_channel     <= i_channel;
            r_row_addr    <= w_rd_addr;
        end
        if (w_exec_fire) begin
            r_read_data  <= n_read_data;
            r_move_valid <= n_move_valid;
            r_a_bus      <= n_a_bus;
            r_b_bus      <= n_b_bus;
            r_b_to_a     <= n_b_to_a;
            r_last_move  <= n_last_move;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_read_data;
    assign o_move_valid    = r_move_valid;
    assign o_a_bus_address = r_a_bus;
    assign o_b_bus_address = r_b_bus;
    assign o_b_to_a        = r_b_to_a;
    assign o_last_move     = r_last_move;

    `ECDMA_ASSERT_NEXT(a_wr_ends_item, w_ram_wr_en, r_state == ST_IDLE, "row write did not end item")
    `ECDMA_ASSERT(a_move_no_read, (o_out_valid && o_move_valid) |-> (o_read_data == 8'd0), "move with read data")
    `ECDMA_ASSERT_NEXT(a_last_idles, w_exec_fire && n_last_move, !r_engine_active, "engine still active after last move")
    `ECDMA_ASSERT(a_active_count, r_engine_active |-> (r_remaining != 17'd0), "active engine with empty count")

endmodule

`default_nettype wire
